FILE: src/bgpc_pkg.sv
// Shared types and constants for the breathing glow pixel color block.
// Used by bgpc_cfg, bgpc_pipe and the top level; no dependencies.
package bgpc_pkg;

  localparam int MAX_PIXELS = 4096;

  // Reciprocal scaling shifts for the divide-by-constant multiplies
  localparam int PER_SH  = 42;
  localparam int HALF_SH = 34;
  localparam int W_SH    = 24;

  // Bits of the center / half-width remainder sweep
  localparam int MOD_ITER = 12;

  localparam int IDX_W = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_CENTER    = 3'd0,
    REG_SEGLEN    = 3'd1,
    REG_SPEED     = 3'd2,
    REG_INTENSITY = 3'd3,
    REG_COLOR     = 3'd4
  } bgpc_reg_t;

  // Settings derived from the register file, held steady while items flow
  typedef struct packed {
    logic [12:0] len;     // saturated segment length
    logic [11:0] c;       // center mod len
    logic [11:0] wm;      // half-width mod len
    logic [6:0]  w;       // glow half-width
    logic [12:0] period;  // breath period in ms
    logic [11:0] half;    // period / 2
    logic [31:0] r1;      // floor(2^42 / period)
    logic [24:0] m2;      // ceil(2^34 / half)
    logic [24:0] mw;      // ceil(2^24 / w)
    logic [23:0] col;     // effective RGB base color
  } bgpc_cfg_t;

endpackage

FILE: src/bgpc_cfg.sv
// Register file and derived settings for the breathing glow block.
// Depends on bgpc_pkg; a write restarts the remainder sweep.
module bgpc_cfg import bgpc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [31:0]      cfg_data,
  output bgpc_cfg_t        cfg_o,
  output logic             busy
);

  logic [11:0] center_r;
  logic [12:0] seglen_r;
  logic [7:0]  speed_r;
  logic [7:0]  intensity_r;
  logic [31:0] color_r;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [12:0] crem_r, crem_nxt;
  logic [12:0] wrem_r, wrem_nxt;
  bgpc_cfg_t   cfg_r;

  logic [31:0] r1_tab [256];
  logic [24:0] m2_tab [256];
  logic [6:0]  w_tab  [256];
  logic [24:0] mw_tab [256];

  // Constant tables indexed by speed and by intensity
  for (genvar s = 0; s < 256; s++) begin : g_tab
    localparam logic [63:0] P  = 64'd1500 + 64'(255 - s) * 64'd20;
    localparam logic [63:0] H  = P / 64'd2;
    localparam logic [63:0] R1 = (64'd1 << PER_SH) / P;
    localparam logic [63:0] M2 = ((64'd1 << HALF_SH) + H - 64'd1) / H;
    localparam logic [63:0] W  = 64'd1 + (64'(s) * 64'd126) / 64'd255;
    localparam logic [63:0] MW = ((64'd1 << W_SH) + W - 64'd1) / W;
    assign r1_tab[s] = R1[31:0];
    assign m2_tab[s] = M2[24:0];
    assign w_tab[s]  = W[6:0];
    assign mw_tab[s] = MW[24:0];
  end

  logic [12:0] len;
  logic [6:0]  w;
  logic [12:0] period;
  logic [3:0]  bidx;
  logic [13:0] csh, wsh;
  logic [11:0] wext;
  logic        wr;

  assign wr     = cfg_valid & cfg_ready;
  assign len    = (seglen_r > 13'(MAX_PIXELS)) ? 13'(MAX_PIXELS) : seglen_r;
  assign w      = w_tab[intensity_r];
  assign wext   = {5'd0, w};
  assign period = 13'd1500 + 13'(8'd255 - speed_r) * 13'd20;
  assign bidx   = cnt_r - 4'd1;
  assign csh    = {crem_r, center_r[bidx]};
  assign wsh    = {wrem_r, wext[bidx]};

  always_comb begin
    cnt_nxt  = cnt_r;
    crem_nxt = crem_r;
    wrem_nxt = wrem_r;
    if (wr) begin
      cnt_nxt  = 4'(MOD_ITER);
      crem_nxt = '0;
      wrem_nxt = '0;
    end else if (cnt_r != 4'd0) begin
      cnt_nxt  = cnt_r - 4'd1;
      crem_nxt = (csh >= {1'b0, len}) ? 13'(csh - {1'b0, len}) : csh[12:0];
      wrem_nxt = (wsh >= {1'b0, len}) ? 13'(wsh - {1'b0, len}) : wsh[12:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r    <= 12'd0;
      seglen_r    <= 13'd712;
      speed_r     <= 8'd80;
      intensity_r <= 8'd90;
      color_r     <= 32'd0;
      cnt_r       <= 4'(MOD_ITER);
      crem_r      <= '0;
      wrem_r      <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      crem_r <= crem_nxt;
      wrem_r <= wrem_nxt;
      if (wr) begin
        unique case (cfg_index)
          REG_CENTER:    center_r    <= cfg_data[11:0];
          REG_SEGLEN:    seglen_r    <= cfg_data[12:0];
          REG_SPEED:     speed_r     <= cfg_data[7:0];
          REG_INTENSITY: intensity_r <= cfg_data[7:0];
          REG_COLOR:     color_r     <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Refresh derived settings every cycle of the sweep
  always_ff @(posedge clk) begin
    if (cnt_r != 4'd0) begin
      cfg_r.len    <= len;
      cfg_r.c      <= crem_nxt[11:0];
      cfg_r.wm     <= wrem_nxt[11:0];
      cfg_r.w      <= w;
      cfg_r.period <= period;
      cfg_r.half   <= period[12:1];
      cfg_r.r1     <= r1_tab[speed_r];
      cfg_r.m2     <= m2_tab[speed_r];
      cfg_r.mw     <= mw_tab[intensity_r];
      cfg_r.col    <= (color_r == 32'd0) ? 24'hFF0000 : color_r[23:0];
    end
  end

  assign cfg_ready = 1'b1;
  assign busy      = cnt_r != 4'd0;
  assign cfg_o     = cfg_r;

`ifndef SYNTHESIS
  a_sweep_len: assert property (@(posedge clk) disable iff (!rst_n)
    wr |=> cnt_r == 4'(MOD_ITER))
    else $error("write did not restart sweep");
  a_sweep_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != 4'd0 && !wr) |=> cnt_r == $past(cnt_r) - 4'd1)
    else $error("sweep counter skipped");
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 4'd0 && len != 13'd0) |-> crem_r < len)
    else $error("center remainder out of range");
`endif

endmodule

FILE: src/bgpc_pipe.sv
// Eight-stage color datapath: breath phase, falloff and channel scaling.
// Depends on bgpc_pkg and the derived settings from bgpc_cfg.
module bgpc_pipe import bgpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  bgpc_cfg_t   cfg,
  input  logic        hold,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] now_ms,
  input  logic [11:0] pixel_index,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [11:0] pixel_out,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue
);

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r;
  logic en1, en2, en3, en4, en5, en6, en7, en8;

  assign en8 = !v8_r | out_tready;
  assign en7 = !v7_r | en8;
  assign en6 = !v6_r | en7;
  assign en5 = !v5_r | en6;
  assign en4 = !v4_r | en5;
  assign en3 = !v3_r | en4;
  assign en2 = !v2_r | en3;
  assign en1 = !v1_r | en2;
  assign in_tready = en1 & !hold;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      {v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r} <= '0;
    end else begin
      if (en1) v1_r <= in_tvalid & in_tready;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
      if (en7) v7_r <= v6_r;
      if (en8) v8_r <= v7_r;
    end
  end

  // Stage 1: period quotient estimate, ring distance to center
  logic [13:0] s1_now_r;
  logic [11:0] s1_pix_r;
  logic [21:0] s1_q_r;
  logic [12:0] s1_d_r;
  logic        s1_inr_r;
  logic [63:0] prod1;
  logic [13:0] dsum;

  assign prod1 = 64'(now_ms) * 64'(cfg.r1);
  assign dsum  = 14'(pixel_index) + 14'(cfg.len) - 14'(cfg.c);

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_now_r <= now_ms[13:0];
      s1_pix_r <= pixel_index;
      s1_q_r   <= prod1[PER_SH +: 22];
      s1_d_r   <= (dsum >= 14'(cfg.len)) ? 13'(dsum - 14'(cfg.len)) : dsum[12:0];
      s1_inr_r <= (cfg.len != 13'd0) && (13'(pixel_index) < cfg.len);
    end
  end

  // Stage 2: quotient times period, offset from the half-width edge
  logic [13:0] s2_now_r;
  logic [11:0] s2_pix_r;
  logic [13:0] s2_qp_r;
  logic        s2_hit_r;
  logic [6:0]  s2_dist_r;
  logic [34:0] qp;
  logic [13:0] bsum;
  logic [12:0] back;

  assign qp   = 35'(s1_q_r) * 35'(cfg.period);
  assign bsum = 14'(cfg.wm) + 14'(cfg.len) - 14'(s1_d_r);
  assign back = (bsum >= 14'(cfg.len)) ? 13'(bsum - 14'(cfg.len)) : bsum[12:0];

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_now_r  <= s1_now_r;
      s2_pix_r  <= s1_pix_r;
      s2_qp_r   <= qp[13:0];
      s2_hit_r  <= s1_inr_r && (back <= {5'd0, cfg.w, 1'b0});
      s2_dist_r <= (back <= 13'(cfg.w)) ? 7'(13'(cfg.w) - back) : 7'(back - 13'(cfg.w));
    end
  end

  // Stage 3: phase within the period, falloff quotient
  logic [12:0] s3_pos_r;
  logic [11:0] s3_pix_r;
  logic        s3_hit_r;
  logic [7:0]  s3_fq_r;
  logic [13:0] rem;
  logic [39:0] fprod;

  assign rem   = s2_now_r - s2_qp_r;
  assign fprod = 40'({s2_dist_r, 8'd0} - 15'(s2_dist_r)) * 40'(cfg.mw);

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_pos_r <= (rem >= 14'(cfg.period)) ? 13'(rem - 14'(cfg.period)) : rem[12:0];
      s3_pix_r <= s2_pix_r;
      s3_hit_r <= s2_hit_r;
      s3_fq_r  <= fprod[W_SH +: 8];
    end
  end

  // Stage 4: pick the rising or falling half of the triangle
  logic [19:0] s4_x_r;
  logic        s4_desc_r;
  logic [7:0]  s4_fall_r;
  logic [11:0] s4_pix_r;
  logic        s4_hit_r;
  logic        desc;
  logic [11:0] ph;

  assign desc = s3_pos_r >= 13'(cfg.half);
  assign ph   = desc ? 12'(s3_pos_r - 13'(cfg.half)) : s3_pos_r[11:0];

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_x_r    <= {ph, 8'd0} - 20'(ph);
      s4_desc_r <= desc;
      s4_fall_r <= 8'd255 - s3_fq_r;
      s4_pix_r  <= s3_pix_r;
      s4_hit_r  <= s3_hit_r;
    end
  end

  // Stage 5: divide by the half period
  logic [7:0]  s5_q_r;
  logic        s5_desc_r;
  logic [7:0]  s5_fall_r;
  logic [11:0] s5_pix_r;
  logic        s5_hit_r;
  logic [44:0] tprod;

  assign tprod = 45'(s4_x_r) * 45'(cfg.m2);

  always_ff @(posedge clk) begin
    if (en5) begin
      s5_q_r    <= tprod[HALF_SH +: 8];
      s5_desc_r <= s4_desc_r;
      s5_fall_r <= s4_fall_r;
      s5_pix_r  <= s4_pix_r;
      s5_hit_r  <= s4_hit_r;
    end
  end

  // Stage 6: lift the triangle into the breath range
  logic [7:0]  s6_breath_r;
  logic [7:0]  s6_fall_r;
  logic [11:0] s6_pix_r;
  logic        s6_hit_r;
  logic [7:0]  tri_lvl;
  logic [15:0] tscaled;

  assign tri_lvl = s5_desc_r ? 8'd255 - s5_q_r : s5_q_r;
  assign tscaled = 16'(tri_lvl) * 16'd216;

  always_ff @(posedge clk) begin
    if (en6) begin
      s6_breath_r <= 8'd40 + tscaled[15:8];
      s6_fall_r   <= s5_fall_r;
      s6_pix_r    <= s5_pix_r;
      s6_hit_r    <= s5_hit_r;
    end
  end

  // Stage 7: combine falloff and breath
  logic [7:0]  s7_level_r;
  logic [11:0] s7_pix_r;
  logic        s7_hit_r;
  logic [16:0] lprod;

  assign lprod = 17'(s6_fall_r) * (17'(s6_breath_r) + 17'd1);

  always_ff @(posedge clk) begin
    if (en7) begin
      s7_level_r <= lprod[15:8];
      s7_pix_r   <= s6_pix_r;
      s7_hit_r   <= s6_hit_r;
    end
  end

  // Stage 8: scale each channel, black outside the glow
  logic [7:0]  s8_r_r, s8_g_r, s8_b_r;
  logic [11:0] s8_pix_r;
  logic [16:0] rp, gp, bp, lv1;

  assign lv1 = 17'(s7_level_r) + 17'd1;
  assign rp  = 17'(cfg.col[23:16]) * lv1;
  assign gp  = 17'(cfg.col[15:8]) * lv1;
  assign bp  = 17'(cfg.col[7:0]) * lv1;

  always_ff @(posedge clk) begin
    if (en8) begin
      s8_pix_r <= s7_pix_r;
      s8_r_r   <= s7_hit_r ? rp[15:8] : 8'd0;
      s8_g_r   <= s7_hit_r ? gp[15:8] : 8'd0;
      s8_b_r   <= s7_hit_r ? bp[15:8] : 8'd0;
    end
  end

  assign out_tvalid = v8_r;
  assign pixel_out  = s8_pix_r;
  assign red        = s8_r_r;
  assign green      = s8_g_r;
  assign blue       = s8_b_r;

`ifndef SYNTHESIS
  a_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !hold) |-> s3_pos_r < cfg.period)
    else $error("breath phase not below period");
  a_dist: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && s2_hit_r && !hold) |-> s2_dist_r <= cfg.w)
    else $error("glow distance beyond half-width");
  a_breath: assert property (@(posedge clk) disable iff (!rst_n)
    v6_r |-> s6_breath_r >= 8'd40)
    else $error("breath level below floor");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    hold |-> !in_tready)
    else $error("item taken during settings sweep");
`endif

endmodule

FILE: src/breathing_glow_pixel_color.sv
// Breathing glow pixel color: for each (time, pixel) transfer returns the
// pixel's RGB color under a breathing glow.
//
// Channels: in_* carries now_ms and pixel_index; out_* carries pixel_out and
// red, green, blue. cfg_* writes one register per transfer:
// 0 center_led, 1 segment_length, 2 speed, 3 intensity, 4 base RGB color;
// other indexes are ignored.
// Throughput: one item per cycle while out_tready is high and no remainder
// sweep is running, set by the eight-stage datapath.
// After reset and after every configuration write the block recomputes the
// center and half-width remainders bit by bit; in_tready stays
// low during that sweep. Configuration transfers are always taken.
// When the receiver stalls, the result holds on out_tdata and the stages
// behind it keep filling; the stall drops in_tready only once all eight stages are
// full. Reset clears all valid bits and restores register defaults.
module breathing_glow_pixel_color import bgpc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [47:0]      in_tdata,   // [31:0] now_ms, [43:32] pixel_index, zero pad
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [39:0]      out_tdata,  // [11:0] pixel_out, [19:12] red,
                                       // [27:20] green, [35:28] blue, zero pad
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [31:0]      cfg_data
);

  bgpc_cfg_t   cfg;
  logic        busy;
  logic [11:0] pixel_out;
  logic [7:0]  red, green, blue;

  bgpc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg),
    .busy      (busy)
  );

  bgpc_pipe u_pipe (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .hold        (busy),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .now_ms      (in_tdata[31:0]),
    .pixel_index (in_tdata[43:32]),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .pixel_out   (pixel_out),
    .red         (red),
    .green       (green),
    .blue        (blue)
  );

  assign out_tdata = {4'd0, blue, green, red, pixel_out};

endmodule
